// File: design/detection_row_decoder_top_assert.svh
// assertion macros for the detection row decoder top level
// depends on nothing; included by detection_row_decoder_top.sv
`ifndef DETECTION_ROW_DECODER_TOP_ASSERT_SVH
`define DETECTION_ROW_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define DRD_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/drd_pkg.sv
// shared constants, config register map, config struct and arithmetic helpers
// for the detection row decoder; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package drd_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_CLASSES  = 80;
    localparam int BOX_FIELDS   = 5;
    localparam int COORDS       = BOX_FIELDS - 1;
    localparam int ROW_LAST_MAX = MAX_CLASSES + BOX_FIELDS - 1;
    localparam int POS_W        = $clog2(ROW_LAST_MAX + 1);
    localparam int CLS_W        = 7;
    localparam int CNT_W        = 7;
    localparam int THR_W        = 16;
    localparam int OUT_W        = 16;
    localparam int DATA_W       = 32;
    localparam int REG_COUNT    = 8;
    localparam int ADDR_W       = $clog2(REG_COUNT * 4);
    localparam int IDX_W        = $clog2(REG_COUNT);

    // scaled coordinate width after dropping the fraction bits of a 64-bit product
    localparam int FIX_W    = 64 - FRAC_BITS;
    localparam int HI_W     = FIX_W - 32;
    localparam int EDGE_W   = FIX_W + 2;
    localparam int FULL_W   = HI_W + 65;
    localparam int MAG_W    = 33;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = MAG_W + MUL_B_W;

    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SCORE_THRESHOLD = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_INV_SCALE_X     = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_INV_SCALE_Y     = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_PAD_X           = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_PAD_Y           = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_RATIO_W         = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_RATIO_H         = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_CLASS_COUNT     = IDX_W'(7);

    // reset values
    localparam logic [THR_W-1:0]  RST_SCORE_THRESHOLD = THR_W'(16384);
    localparam logic [DATA_W-1:0] RST_UNITY           = DATA_W'(65536);
    localparam logic [DATA_W-1:0] RST_PAD             = '0;
    localparam logic [CNT_W-1:0]  RST_CLASS_COUNT     = CNT_W'(80);

    typedef struct packed {
        logic [THR_W-1:0]         score_threshold;
        logic [DATA_W-1:0]        inv_scale_x;
        logic [DATA_W-1:0]        inv_scale_y;
        logic signed [DATA_W-1:0] pad_x;
        logic signed [DATA_W-1:0] pad_y;
        logic [DATA_W-1:0]        ratio_w;
        logic [DATA_W-1:0]        ratio_h;
        logic [CNT_W-1:0]         class_count;
    } cfg_t;

    // product magnitude limited to the signed 64-bit maximum
    function automatic logic [63:0] sat_mag(input logic [PROD_W-1:0] mag);
        if (mag > PROD_W'(SAT_POS)) begin
            return SAT_POS;
        end
        return mag[63:0];
    endfunction

    function automatic logic [OUT_W-1:0] clamp_u16(input logic [63:0] v);
        if (v > 64'(16'hFFFF)) begin
            return '1;
        end
        return v[OUT_W-1:0];
    endfunction

    // round(x - w/2) in pixels, half away from zero, clamped to 0..65535
    function automatic logic [OUT_W-1:0] edge_round(input logic [FIX_W-1:0] x,
                                                    input logic [FIX_W-1:0] w);
        logic [EDGE_W-1:0] v;
        logic [EDGE_W-1:0] s;
        v = {x[FIX_W-1], x, 1'b0} - {{2{w[FIX_W-1]}}, w};
        s = v + (EDGE_W'(1) << FRAC_BITS);
        if (v[EDGE_W-1]) begin
            return '0;
        end
        return clamp_u16(64'(s >> (FRAC_BITS + 1)));
    endfunction

    // size times ratio from two partial products, saturated then rounded
    function automatic logic [OUT_W-1:0] ratio_round(input logic [PROD_W-1:0] hi,
                                                     input logic [63:0] lo);
        logic [FULL_W-1:0] full;
        logic [63:0]       ps;
        logic [63:0]       rs;
        full = {1'b0, hi[HI_W+31:0], 32'b0} + FULL_W'(lo);
        if (full > FULL_W'(SAT_POS)) begin
            ps = SAT_POS;
        end else begin
            ps = full[63:0];
        end
        rs = (ps + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        return clamp_u16(rs);
    endfunction

endpackage

`default_nettype wire

// File: design/detection_row_decoder_top.sv
// detection row decoder top level: row tracking, decision sequencer, result register
// depends on drd_pkg, drd_cfg, drd_mul and detection_row_decoder_top_assert.svh
//
//   channel | ports                       | role
//   --------+-----------------------------+------------------------------------------
//   s_      | s_valid s_ready s_tensor_*  | one tensor value per item, row order
//   m_      | m_valid m_ready m_class_id..| one box item per kept row
//   apb     | psel penable pwrite paddr.. | eight 32-bit registers at 4*index
//
// every value but a row's last is taken as soon as it is valid
// the last value of a row holds s_ready low while one shared 33x32 multiplier works
//   the product, x, y, w, h and two partial products per size;
//   a row dropped on objectness ends in S_P, one dropped on the product in S_X
// a finished box waits in the output register; only the next row's finish stalls on it
// reset (synchronous, active low) clears the row position, the sequencer and m_valid
`timescale 1ns / 1ps
`default_nettype none

`include "detection_row_decoder_top_assert.svh"

module detection_row_decoder_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // tensor value stream
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [31:0]          s_tensor_value,
    // box results
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [drd_pkg::CLS_W-1:0]        m_class_id,
    output logic [drd_pkg::OUT_W-1:0]        m_confidence,
    output logic [drd_pkg::OUT_W-1:0]        m_box_left,
    output logic [drd_pkg::OUT_W-1:0]        m_box_top,
    output logic [drd_pkg::OUT_W-1:0]        m_box_width,
    output logic [drd_pkg::OUT_W-1:0]        m_box_height,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [drd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [drd_pkg::DATA_W-1:0]  pwdata,
    output logic      [drd_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int PW  = drd_pkg::POS_W;
    localparam int CW  = drd_pkg::CLS_W;
    localparam int CNW = drd_pkg::CNT_W;
    localparam int FW  = drd_pkg::FIX_W;
    localparam int F   = drd_pkg::FRAC_BITS;
    localparam int MW  = drd_pkg::MAG_W;

    // sequencer: states S_P to S_HH each issue one use of the shared multiplier
    typedef enum logic [11:0] {
        S_RUN = 12'b0000_0000_0001,  // taking tensor values
        S_P   = 12'b0000_0000_0010,  // objectness check, issue score * objectness
        S_X   = 12'b0000_0000_0100,  // product check, issue (cx - pad_x) * inv_x
        S_Y   = 12'b0000_0000_1000,  // store x, issue (cy - pad_y) * inv_y
        S_W   = 12'b0000_0001_0000,  // store y, issue w * inv_x
        S_H   = 12'b0000_0010_0000,  // store w, issue h * inv_y
        S_WL  = 12'b0000_0100_0000,  // store h, issue low part of |w| * ratio_w
        S_WH  = 12'b0000_1000_0000,  // hold low part, issue high part
        S_HL  = 12'b0001_0000_0000,  // width and edges, issue low part of |h| * ratio_h
        S_HH  = 12'b0010_0000_0000,  // hold low part, issue high part
        S_FIN = 12'b0100_0000_0000,  // height
        S_OUT = 12'b1000_0000_0000   // hand the box to the output register
    } state_t;

    drd_pkg::cfg_t cfg;

    state_t state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;

    // row payload
    logic signed [31:0] box_reg [drd_pkg::COORDS];
    logic signed [31:0] box_next [drd_pkg::COORDS];
    logic signed [31:0] obj_reg, obj_next;
    logic signed [31:0] best_reg, best_next;
    logic [CW-1:0]      class_reg, class_next;

    // decision work registers
    logic [FW-1:0]               x_reg, x_next, y_reg, y_next;
    logic [FW-1:0]               w_reg, w_next, h_reg, h_next;
    logic [63:0]                 acc_reg, acc_next;
    logic [drd_pkg::OUT_W-1:0]   conf_reg, conf_next;
    logic [drd_pkg::OUT_W-1:0]   left_reg, left_next, top_reg, top_next;
    logic [drd_pkg::OUT_W-1:0]   width_reg, width_next, height_reg, height_next;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic [CW-1:0]               m_class_reg, m_class_next;
    logic [drd_pkg::OUT_W-1:0]   m_conf_reg, m_conf_next;
    logic [drd_pkg::OUT_W-1:0]   m_left_reg, m_left_next, m_top_reg, m_top_next;
    logic [drd_pkg::OUT_W-1:0]   m_width_reg, m_width_next, m_height_reg, m_height_next;

    // shared multiplier
    logic [MW-1:0]               mul_a;
    logic [31:0]                 mul_b;
    logic                        mul_neg;
    logic [drd_pkg::PROD_W-1:0]  p_mag;
    logic                        p_neg;
    logic [63:0]                 mul_mag;
    logic signed [63:0]          mul_res;
    logic [FW-1:0]               mul_scaled;

    logic [PW-1:0]      eff_classes;
    logic [PW-1:0]      row_last;
    logic               obj_below;
    logic [63:0]        thr_prod;
    logic               prod_low;
    logic [31:0]        best_mag, obj_mag;
    logic signed [MW-1:0] dx, dy;
    logic [MW-1:0]      dx_mag, dy_mag;
    logic [31:0]        win_mag, hin_mag;
    logic [FW-1:0]      w_mag, h_mag;
    logic               out_free;

    drd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drd_mul u_mul (
        .aclk  (aclk),
        .a_mag (mul_a),
        .b_mag (mul_b),
        .neg   (mul_neg),
        .p_mag (p_mag),
        .p_neg (p_neg)
    );

    // class count of 0 acts as 1, above the maximum acts as the maximum
    always_comb begin
        if (cfg.class_count == '0) begin
            eff_classes = PW'(1);
        end else if (cfg.class_count > CNW'(drd_pkg::MAX_CLASSES)) begin
            eff_classes = PW'(drd_pkg::MAX_CLASSES);
        end else begin
            eff_classes = PW'(cfg.class_count);
        end
    end
    assign row_last = eff_classes + PW'(drd_pkg::BOX_FIELDS - 1);

    // signed view of the registered product, saturated to the 64-bit range
    assign mul_mag    = drd_pkg::sat_mag(p_mag);
    assign mul_res    = p_neg ? -$signed(mul_mag) : $signed(mul_mag);
    assign mul_scaled = FW'(mul_res >>> F);

    // objectness against the threshold, then score * objectness against threshold << 16
    assign obj_below = obj_reg < $signed(32'(cfg.score_threshold));
    assign thr_prod  = 64'(cfg.score_threshold) << (2 * F - 16);
    assign prod_low  = mul_res < $signed(thr_prod);

    // operand magnitudes
    assign best_mag = best_reg[31] ? 32'(-best_reg) : 32'(best_reg);
    assign obj_mag  = obj_reg[31] ? 32'(-obj_reg) : 32'(obj_reg);
    assign dx       = {box_reg[0][31], box_reg[0]} - {cfg.pad_x[31], cfg.pad_x};
    assign dy       = {box_reg[1][31], box_reg[1]} - {cfg.pad_y[31], cfg.pad_y};
    assign dx_mag   = dx[MW-1] ? MW'(-dx) : MW'(dx);
    assign dy_mag   = dy[MW-1] ? MW'(-dy) : MW'(dy);
    assign win_mag  = box_reg[2][31] ? 32'(-box_reg[2]) : 32'(box_reg[2]);
    assign hin_mag  = box_reg[3][31] ? 32'(-box_reg[3]) : 32'(box_reg[3]);
    assign w_mag    = w_reg[FW-1] ? -w_reg : w_reg;
    assign h_mag    = h_reg[FW-1] ? -h_reg : h_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        box_next    = box_reg;
        obj_next    = obj_reg;
        best_next   = best_reg;
        class_next  = class_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        acc_next    = acc_reg;
        conf_next   = conf_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        width_next  = width_reg;
        height_next = height_reg;
        mul_a       = '0;
        mul_b       = '0;
        mul_neg     = 1'b0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_class_next  = m_class_reg;
        m_conf_next   = m_conf_reg;
        m_left_next   = m_left_reg;
        m_top_next    = m_top_reg;
        m_width_next  = m_width_reg;
        m_height_next = m_height_reg;

        case (state_reg)
            S_RUN: begin
                if (s_valid) begin
                    // route the value by its place in the row
                    if (pos_reg < PW'(drd_pkg::COORDS)) begin
                        box_next[pos_reg[1:0]] = s_tensor_value;
                    end else if (pos_reg == PW'(drd_pkg::COORDS)) begin
                        obj_next = s_tensor_value;
                    end else if (pos_reg == PW'(drd_pkg::BOX_FIELDS)) begin
                        best_next  = s_tensor_value;
                        class_next = '0;
                    end else if (s_tensor_value > best_reg) begin
                        // strict compare keeps the lowest index on ties
                        best_next  = s_tensor_value;
                        class_next = CW'(pos_reg - PW'(drd_pkg::BOX_FIELDS));
                    end
                    // a shortened class count ends the row at once
                    if (pos_reg >= row_last) begin
                        pos_next   = '0;
                        state_next = S_P;
                    end else begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
            end
            S_P: begin
                mul_a   = {1'b0, best_mag};
                mul_b   = obj_mag;
                mul_neg = best_reg[31] ^ obj_reg[31];
                state_next = obj_below ? S_RUN : S_X;
            end
            S_X: begin
                conf_next = drd_pkg::clamp_u16(64'(mul_res) >> (2 * F - 16));
                mul_a     = dx_mag;
                mul_b     = cfg.inv_scale_x;
                mul_neg   = dx[MW-1];
                state_next = prod_low ? S_RUN : S_Y;
            end
            S_Y: begin
                x_next     = mul_scaled;
                mul_a      = dy_mag;
                mul_b      = cfg.inv_scale_y;
                mul_neg    = dy[MW-1];
                state_next = S_W;
            end
            S_W: begin
                y_next     = mul_scaled;
                mul_a      = {1'b0, win_mag};
                mul_b      = cfg.inv_scale_x;
                mul_neg    = box_reg[2][31];
                state_next = S_H;
            end
            S_H: begin
                w_next     = mul_scaled;
                mul_a      = {1'b0, hin_mag};
                mul_b      = cfg.inv_scale_y;
                mul_neg    = box_reg[3][31];
                state_next = S_WL;
            end
            S_WL: begin
                h_next     = mul_scaled;
                mul_a      = {1'b0, w_mag[31:0]};
                mul_b      = cfg.ratio_w;
                state_next = S_WH;
            end
            S_WH: begin
                acc_next   = p_mag[63:0];
                mul_a      = MW'(w_mag[FW-1:32]);
                mul_b      = cfg.ratio_w;
                state_next = S_HL;
            end
            S_HL: begin
                // negative size scales to a negative value, clamped to zero
                width_next = w_reg[FW-1] ? '0 : drd_pkg::ratio_round(p_mag, acc_reg);
                left_next  = drd_pkg::edge_round(x_reg, w_reg);
                top_next   = drd_pkg::edge_round(y_reg, h_reg);
                mul_a      = {1'b0, h_mag[31:0]};
                mul_b      = cfg.ratio_h;
                state_next = S_HH;
            end
            S_HH: begin
                acc_next   = p_mag[63:0];
                mul_a      = MW'(h_mag[FW-1:32]);
                mul_b      = cfg.ratio_h;
                state_next = S_FIN;
            end
            S_FIN: begin
                height_next = h_reg[FW-1] ? '0 : drd_pkg::ratio_round(p_mag, acc_reg);
                state_next  = S_OUT;
            end
            S_OUT: begin
                // wait for room in the output register
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_class_next  = class_reg;
                    m_conf_next   = conf_reg;
                    m_left_next   = left_reg;
                    m_top_next    = top_reg;
                    m_width_next  = width_reg;
                    m_height_next = height_reg;
                    state_next    = S_RUN;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RUN;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        box_reg      <= box_next;
        obj_reg      <= obj_next;
        best_reg     <= best_next;
        class_reg    <= class_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        acc_reg      <= acc_next;
        conf_reg     <= conf_next;
        left_reg     <= left_next;
        top_reg      <= top_next;
        width_reg    <= width_next;
        height_reg   <= height_next;
        m_class_reg  <= m_class_next;
        m_conf_reg   <= m_conf_next;
        m_left_reg   <= m_left_next;
        m_top_reg    <= m_top_next;
        m_width_reg  <= m_width_next;
        m_height_reg <= m_height_next;
    end

    assign s_ready      = (state_reg == S_RUN);
    assign m_valid      = m_valid_reg;
    assign m_class_id   = m_class_reg;
    assign m_confidence = m_conf_reg;
    assign m_box_left   = m_left_reg;
    assign m_box_top    = m_top_reg;
    assign m_box_width  = m_width_reg;
    assign m_box_height = m_height_reg;

    // row position never runs past the longest row
    `DRD_ASSERT_HOLDS(a_pos_range, aclk, aresetn, 1'b1, pos_reg <= PW'(drd_pkg::ROW_LAST_MAX), "row position out of range")
    // the sequencer only runs between rows
    `DRD_ASSERT_HOLDS(a_pos_idle, aclk, aresetn, state_reg != S_RUN, pos_reg == '0, "sequencer busy mid-row")
    // low objectness drops the row without further work
    `DRD_ASSERT_NEXT(a_obj_drop, aclk, aresetn, (state_reg == S_P) && obj_below, state_reg == S_RUN, "low objectness row not dropped")
    // a new box only comes from the hand-off state
    `DRD_ASSERT_HOLDS(a_out_src, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == S_OUT, "result raised outside hand-off")

endmodule

`default_nettype wire

// File: design/drd_mul.sv
// shared magnitude multiplier with registered product and sign
// depends on drd_pkg
`timescale 1ns / 1ps
`default_nettype none

module drd_mul (
    input  wire logic                        aclk,
    input  wire logic [drd_pkg::MAG_W-1:0]   a_mag,
    input  wire logic [drd_pkg::MUL_B_W-1:0] b_mag,
    input  wire logic                        neg,
    output logic      [drd_pkg::PROD_W-1:0]  p_mag,
    output logic                             p_neg
);

    logic [drd_pkg::PROD_W-1:0] prod_reg;
    logic [drd_pkg::PROD_W-1:0] prod_next;
    logic                       neg_reg;

    always_comb begin
        prod_next = {{drd_pkg::MUL_B_W{1'b0}}, a_mag} * {{drd_pkg::MAG_W{1'b0}}, b_mag};
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        neg_reg  <= neg;
    end

    assign p_mag = prod_reg;
    assign p_neg = neg_reg;

endmodule

`default_nettype wire

// File: design/drd_cfg.sv
// apb-style configuration registers of the detection row decoder
// depends on drd_pkg
`timescale 1ns / 1ps
`default_nettype none

module drd_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [drd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [drd_pkg::DATA_W-1:0] pwdata,
    output logic      [drd_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output drd_pkg::cfg_t                   cfg
);

    drd_pkg::cfg_t                 cfg_reg;
    drd_pkg::cfg_t                 cfg_next;
    logic [drd_pkg::IDX_W-1:0]     reg_idx;
    logic                          wr_en;

    assign reg_idx = paddr[drd_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                drd_pkg::REG_SCORE_THRESHOLD:
                    cfg_next.score_threshold = pwdata[drd_pkg::THR_W-1:0];
                drd_pkg::REG_INV_SCALE_X: cfg_next.inv_scale_x = pwdata;
                drd_pkg::REG_INV_SCALE_Y: cfg_next.inv_scale_y = pwdata;
                drd_pkg::REG_PAD_X:       cfg_next.pad_x       = pwdata;
                drd_pkg::REG_PAD_Y:       cfg_next.pad_y       = pwdata;
                drd_pkg::REG_RATIO_W:     cfg_next.ratio_w     = pwdata;
                drd_pkg::REG_RATIO_H:     cfg_next.ratio_h     = pwdata;
                drd_pkg::REG_CLASS_COUNT:
                    cfg_next.class_count = pwdata[drd_pkg::CNT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.score_threshold <= drd_pkg::RST_SCORE_THRESHOLD;
            cfg_reg.inv_scale_x     <= drd_pkg::RST_UNITY;
            cfg_reg.inv_scale_y     <= drd_pkg::RST_UNITY;
            cfg_reg.pad_x           <= drd_pkg::RST_PAD;
            cfg_reg.pad_y           <= drd_pkg::RST_PAD;
            cfg_reg.ratio_w         <= drd_pkg::RST_UNITY;
            cfg_reg.ratio_h         <= drd_pkg::RST_UNITY;
            cfg_reg.class_count     <= drd_pkg::RST_CLASS_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            drd_pkg::REG_SCORE_THRESHOLD:
                prdata = drd_pkg::DATA_W'(cfg_reg.score_threshold);
            drd_pkg::REG_INV_SCALE_X: prdata = cfg_reg.inv_scale_x;
            drd_pkg::REG_INV_SCALE_Y: prdata = cfg_reg.inv_scale_y;
            drd_pkg::REG_PAD_X:       prdata = cfg_reg.pad_x;
            drd_pkg::REG_PAD_Y:       prdata = cfg_reg.pad_y;
            drd_pkg::REG_RATIO_W:     prdata = cfg_reg.ratio_w;
            drd_pkg::REG_RATIO_H:     prdata = cfg_reg.ratio_h;
            drd_pkg::REG_CLASS_COUNT: prdata = drd_pkg::DATA_W'(cfg_reg.class_count);
            default:                  prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: test/drd_box_checker.sv
// box checker for the detection row decoder: tracks config writes and tensor items,
// predicts each kept row's box and compares it with the result channel
// depends on drd_pkg
`timescale 1ns / 1ps

module drd_box_checker
    import drd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [31:0]       s_tensor_value,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [CLS_W-1:0]         m_class_id,
    input  logic [OUT_W-1:0]         m_confidence,
    input  logic [OUT_W-1:0]         m_box_left,
    input  logic [OUT_W-1:0]         m_box_top,
    input  logic [OUT_W-1:0]         m_box_width,
    input  logic [OUT_W-1:0]         m_box_height,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output int                       fail_count,
    output int                       boxes_waiting
);

    typedef struct packed {
        logic [CLS_W-1:0] class_id;
        logic [OUT_W-1:0] confidence;
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] top;
        logic [OUT_W-1:0] width;
        logic [OUT_W-1:0] height;
    } box_t;

    // shadow copy of the register file
    logic [THR_W-1:0]         thr;
    logic [DATA_W-1:0]        inv_x;
    logic [DATA_W-1:0]        inv_y;
    logic signed [DATA_W-1:0] pad_x;
    logic signed [DATA_W-1:0] pad_y;
    logic [DATA_W-1:0]        ratio_w;
    logic [DATA_W-1:0]        ratio_h;
    logic [CNT_W-1:0]         cls_cnt;

    // row state
    int             row_pos;
    longint         coord [4];
    longint         obj;
    longint         top_score;
    logic [CLS_W-1:0] top_class;

    box_t expected_boxes [$];
    int   boxes_seen;

    // signed times unsigned, magnitude limited to the signed 64-bit maximum
    function automatic longint sat_product(input longint a, input logic [31:0] b);
        logic [63:0]  m;
        logic [127:0] p;
        m = (a < 0) ? 64'(-a) : 64'(a);
        p = 128'(m) * 128'(b);
        if (p > 128'(64'h7FFF_FFFF_FFFF_FFFF)) begin
            p = 128'(64'h7FFF_FFFF_FFFF_FFFF);
        end
        return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // shift right by s, rounding half away from zero
    function automatic longint round_half_away(input longint v, input int s);
        logic [63:0] m;
        logic [63:0] r;
        m = (v < 0) ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [OUT_W-1:0] clamp_pixel(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > 65535) begin
            return '1;
        end
        return OUT_W'(v);
    endfunction

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("box %0d %s: expected %0d, got %0d", boxes_seen, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        longint v;
        longint prod;
        longint x;
        longint y;
        longint w;
        longint h;
        int     eff;
        box_t   want;
        if (!aresetn) begin
            thr           = RST_SCORE_THRESHOLD;
            inv_x         = RST_UNITY;
            inv_y         = RST_UNITY;
            pad_x         = RST_PAD;
            pad_y         = RST_PAD;
            ratio_w       = RST_UNITY;
            ratio_h       = RST_UNITY;
            cls_cnt       = RST_CLASS_COUNT;
            row_pos       = 0;
            coord         = '{0, 0, 0, 0};
            obj           = 0;
            top_score     = 0;
            top_class     = '0;
            boxes_seen    = 0;
            fail_count    = 0;
            expected_boxes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_SCORE_THRESHOLD: thr     = pwdata[THR_W-1:0];
                    REG_INV_SCALE_X:     inv_x   = pwdata;
                    REG_INV_SCALE_Y:     inv_y   = pwdata;
                    REG_PAD_X:           pad_x   = pwdata;
                    REG_PAD_Y:           pad_y   = pwdata;
                    REG_RATIO_W:         ratio_w = pwdata;
                    REG_RATIO_H:         ratio_h = pwdata;
                    REG_CLASS_COUNT:     cls_cnt = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                v = longint'(s_tensor_value);
                eff = (cls_cnt == 0) ? 1 : ((cls_cnt > MAX_CLASSES) ? MAX_CLASSES : cls_cnt);
                if (row_pos < COORDS) begin
                    coord[row_pos] = v;
                end else if (row_pos == COORDS) begin
                    obj = v;
                end else if (row_pos == BOX_FIELDS) begin
                    top_score = v;
                    top_class = '0;
                end else if (v > top_score) begin
                    top_score = v;
                    top_class = CLS_W'(row_pos - BOX_FIELDS);
                end

                // a count lowered mid-row ends the row at once
                if (row_pos >= BOX_FIELDS + eff - 1) begin
                    prod = top_score * obj;
                    if (obj >= longint'(thr) && prod >= (longint'(thr) << 16)) begin
                        x = sat_product(coord[0] - longint'(pad_x), inv_x) >>> FRAC_BITS;
                        y = sat_product(coord[1] - longint'(pad_y), inv_y) >>> FRAC_BITS;
                        w = sat_product(coord[2], inv_x) >>> FRAC_BITS;
                        h = sat_product(coord[3], inv_y) >>> FRAC_BITS;
                        want.class_id   = top_class;
                        want.confidence = clamp_pixel(prod >>> (2 * FRAC_BITS - 16));
                        want.left       = clamp_pixel(round_half_away(2 * x - w, FRAC_BITS + 1));
                        want.top        = clamp_pixel(round_half_away(2 * y - h, FRAC_BITS + 1));
                        want.width      = clamp_pixel(round_half_away(sat_product(w, ratio_w),
                                                                      2 * FRAC_BITS));
                        want.height     = clamp_pixel(round_half_away(sat_product(h, ratio_h),
                                                                      2 * FRAC_BITS));
                        expected_boxes.insert(expected_boxes.size(), want);
                    end
                    row_pos = 0;
                end else begin
                    row_pos++;
                end
            end

            if (m_valid && m_ready) begin
                if (expected_boxes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("box %0d: none expected, got class %0d conf %0d box %0d %0d %0d %0d",
                                 boxes_seen, m_class_id, m_confidence, m_box_left, m_box_top,
                                 m_box_width, m_box_height);
                    end
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("class_id", OUT_W'(want.class_id), OUT_W'(m_class_id));
                    check_field("confidence", want.confidence, m_confidence);
                    check_field("box_left", want.left, m_box_left);
                    check_field("box_top", want.top, m_box_top);
                    check_field("box_width", want.width, m_box_width);
                    check_field("box_height", want.height, m_box_height);
                end
                boxes_seen++;
            end
        end
        boxes_waiting = expected_boxes.size();
    end

endmodule

// File: test/tb.sv
// testbench top for the detection row decoder: clock, reset, tensor stream, result
// back-pressure and register writes; depends on drd_pkg, detection_row_decoder_top, drd_box_checker
`timescale 1ns / 1ps

module tb;
    import drd_pkg::*;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [31:0]        s_tensor_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [CLS_W-1:0]          m_class_id;
    logic [OUT_W-1:0]          m_confidence;
    logic [OUT_W-1:0]          m_box_left;
    logic [OUT_W-1:0]          m_box_top;
    logic [OUT_W-1:0]          m_box_width;
    logic [OUT_W-1:0]          m_box_height;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    int mismatches;
    int boxes_waiting;
    int random_items = 0;
    bit steady = 1'b0;    // no idling on either side while set

    detection_row_decoder_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tensor_value (s_tensor_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_class_id     (m_class_id),
        .m_confidence   (m_confidence),
        .m_box_left     (m_box_left),
        .m_box_top      (m_box_top),
        .m_box_width    (m_box_width),
        .m_box_height   (m_box_height),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    drd_box_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tensor_value (s_tensor_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_class_id     (m_class_id),
        .m_confidence   (m_confidence),
        .m_box_left     (m_box_left),
        .m_box_top      (m_box_top),
        .m_box_width    (m_box_width),
        .m_box_height   (m_box_height),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (mismatches),
        .boxes_waiting  (boxes_waiting)
    );

    // 4 ns clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // result side back-pressure: stalls with a chance of about 19 in 100 unless steady
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 19);
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // setup cycle then access cycle, then back to idle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_setup(input logic [31:0] thr, input logic [31:0] inv_x,
                               input logic [31:0] inv_y, input logic [31:0] pad_x,
                               input logic [31:0] pad_y, input logic [31:0] ratio_w,
                               input logic [31:0] ratio_h, input logic [31:0] cls_cnt);
        write_reg(REG_SCORE_THRESHOLD, thr);
        write_reg(REG_INV_SCALE_X, inv_x);
        write_reg(REG_INV_SCALE_Y, inv_y);
        write_reg(REG_PAD_X, pad_x);
        write_reg(REG_PAD_Y, pad_y);
        write_reg(REG_RATIO_W, ratio_w);
        write_reg(REG_RATIO_H, ratio_h);
        write_reg(REG_CLASS_COUNT, cls_cnt);
    endtask

    // one tensor item; called and returns at a falling edge, valid left high
    task automatic push_value(input logic [31:0] v);
        while (!steady && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_tensor_value <= v;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // drop valid, wait for every predicted box, then let a dropped row's
    // decision pass finish before any register changes
    task automatic settle();
        s_valid <= 1'b0;
        while (boxes_waiting != 0) begin
            @(negedge aclk);
        end
        repeat (24) @(negedge aclk);
    endtask

    // value for a row position: pixel-ish centers and sizes, fractions for scores
    function automatic logic [31:0] row_value(input int pos, input bit wild);
        if (wild) begin
            return $urandom();
        end
        if (pos < 2) begin
            return ($urandom_range(0, 700) << 16) | $urandom_range(0, 65535);
        end
        if (pos < COORDS) begin
            return ($urandom_range(0, 400) << 16) | $urandom_range(0, 65535);
        end
        return $urandom_range(0, 65536);
    endfunction

    task automatic send_row(input int len);
        bit          wild_row;
        logic [31:0] v;
        logic [31:0] last_score;
        wild_row   = ($urandom_range(0, 9) == 0);
        last_score = '0;
        for (int p = 0; p < len; p++) begin
            v = row_value(p, wild_row || ($urandom_range(0, 15) == 0));
            // repeat a score now and then to hit ties
            if (p > BOX_FIELDS && $urandom_range(0, 7) == 0) begin
                v = last_score;
            end
            if (p >= BOX_FIELDS) begin
                last_score = v;
            end
            push_value(v);
            random_items++;
        end
    endtask

    function automatic logic [31:0] pick_unsigned_q(input int mode);
        case (mode)
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            2:       return $urandom();
            default: return $urandom_range(16384, 262144);
        endcase
    endfunction

    function automatic logic [31:0] pick_pad(input int mode);
        case (mode)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom();
            default: return $urandom_range(0, 400 << 16) - (200 << 16);
        endcase
    endfunction

    initial begin
        int          phase;
        int          mode;
        int          eff;
        int          rows;
        int          pick;
        logic [31:0] thr;
        logic [31:0] cls_cnt;

        // reset held low, then released at a falling edge
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // one full row under the reset register values
        send_row(BOX_FIELDS + MAX_CLASSES);
        settle();

        // zero threshold, two classes: extreme coordinates, negative width,
        // zero objectness still passes, tied scores keep the lower index
        write_reg(REG_CLASS_COUNT, 32'd2);
        write_reg(REG_SCORE_THRESHOLD, 32'd0);
        push_value(32'h7FFF_FFFF); push_value(32'h8000_0000); push_value(32'hFFFF_0000);
        push_value(32'h7FFF_FFFF); push_value(32'h0000_0000); push_value(32'h0000_0100);
        push_value(32'h0000_0100);
        // row left open at position 6
        push_value(32'h0064_0000); push_value(32'h0032_0000); push_value(32'h0020_0000);
        push_value(32'h0010_8000); push_value(32'h0001_0000); push_value(32'h0000_8000);
        settle();

        // extreme registers; a zero class count acts as one, so the open row
        // ends on the next item
        write_setup(32'd65535, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'd0);
        push_value(32'h0001_0000);
        // saturated confidence and box products
        push_value(32'h0140_0000); push_value(32'hFFF0_0000); push_value(32'h0050_0000);
        push_value(32'h0030_0000); push_value(32'h7FFF_FFFF); push_value(32'h7FFF_FFFF);
        // dropped on the product
        push_value(32'h0140_0000); push_value(32'h00F0_0000); push_value(32'h0050_0000);
        push_value(32'h0030_0000); push_value(32'h0001_0000); push_value(32'h0000_FFFE);
        // dropped on objectness
        push_value(32'h0140_0000); push_value(32'h00F0_0000); push_value(32'h0050_0000);
        push_value(32'h0030_0000); push_value(32'h0000_FFFE); push_value(32'h0001_0000);

        // random phases, each with its own register setting
        phase = 0;
        while (random_items < 1250) begin
            settle();
            steady = (phase % 5 == 3);
            mode   = $urandom_range(0, 7);
            case (mode)
                0:       thr = 32'd65535;
                1:       thr = 32'd0;
                2:       thr = $urandom_range(0, 65535);
                default: thr = $urandom_range(0, 20000);
            endcase
            // mostly short rows, now and then the full or out-of-range count
            pick = $urandom_range(0, 19);
            case (pick)
                0:       cls_cnt = 32'd0;
                1:       cls_cnt = 32'd127;
                2:       cls_cnt = MAX_CLASSES;
                3:       cls_cnt = $urandom_range(MAX_CLASSES + 1, 126);
                4:       cls_cnt = $urandom() | 32'h0000_0001;
                default: cls_cnt = $urandom_range(1, 8);
            endcase
            write_setup(thr, pick_unsigned_q(mode), pick_unsigned_q(mode), pick_pad(mode),
                        pick_pad(mode), pick_unsigned_q(mode), pick_unsigned_q(mode), cls_cnt);
            cls_cnt = cls_cnt & 32'h7F;
            eff = (cls_cnt == 0) ? 1 : ((cls_cnt > MAX_CLASSES) ? MAX_CLASSES : int'(cls_cnt));
            rows = (eff > 16) ? $urandom_range(1, 2) : $urandom_range(2, 14);
            repeat (rows) send_row(BOX_FIELDS + eff);
            // leave a row open for the next setting now and then
            if ($urandom_range(0, 1) == 1) begin
                send_row($urandom_range(1, BOX_FIELDS + eff - 1));
            end
            phase++;
        end
        settle();
        steady = 1'b0;

        if (mismatches == 0 && boxes_waiting == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
